[hw/rtl/cdta_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cdta_pkg;

    typedef enum logic [2:0] {
        CMD_NEXT_DAY  = 3'd0,
        CMD_PREV_DAY  = 3'd1,
        CMD_BACK_DAYS = 3'd2,
        CMD_ADD_MIN   = 3'd3,
        CMD_SUB_MIN   = 3'd4
    } t_cmd;

    typedef logic [15:0] t_year;
    typedef logic [3:0]  t_month;
    typedef logic [4:0]  t_day;
    typedef logic [4:0]  t_hour;
    typedef logic [5:0]  t_minute;
    typedef logic [5:0]  t_amount;

    localparam t_month  MONTH_FIRST   = 4'd1;
    localparam t_month  MONTH_LAST    = 4'd12;
    localparam t_day    DAY_FIRST     = 5'd1;
    localparam t_day    DAY_DEC_LEN   = 5'd31;
    localparam t_hour   HOUR_LAST     = 5'd23;
    localparam t_minute MINUTE_LAST   = 6'd59;
    localparam t_amount AMOUNT_LAST   = 6'd59;
    localparam t_amount BACK_DAYS_MAX = 6'd28;
    localparam logic [6:0] MIN_PER_HOUR = 7'd60;

    // month length, every year divisible by four is leap
    function automatic t_day month_len(input t_year year, input t_month month);
        t_day len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2: len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/cdta_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface cdta_in_if;
    import cdta_pkg::*;

    logic    valid;
    logic    ready;
    logic [2:0] cmd;
    t_year   year;
    t_month  month;
    t_day    day;
    t_hour   hour;
    t_minute minute;
    t_amount amount;

    modport source (output valid, cmd, year, month, day, hour, minute, amount, input ready);
    modport sink   (input valid, cmd, year, month, day, hour, minute, amount, output ready);
endinterface

interface cdta_out_if;
    import cdta_pkg::*;

    logic    valid;
    logic    ready;
    t_year   out_year;
    t_month  out_month;
    t_day    out_day;
    t_hour   out_hour;
    t_minute out_minute;

    modport source (output valid, out_year, out_month, out_day, out_hour, out_minute,
                    input ready);
    modport sink   (input valid, out_year, out_month, out_day, out_hour, out_minute,
                    output ready);
endinterface

`default_nettype wire

[hw/rtl/calendar_date_time_adjust_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | handshake     | payload
// ---------+-----+---------------+------------------------------------------------
// i_in     | in  | valid / ready | cmd, year, month, day, hour, minute, amount
// o_out    | out | valid / ready | out_year, out_month, out_day, out_hour, out_minute
//
// an accepted beat passes the input register, then the date logic into the
// result register. one beat per cycle sustained while o_out.ready holds.
// synchronous active-low reset clears both valid flags only.
// a stalled result holds; the input register still takes a beat while the
// result register is free or being drained in the same cycle.

module calendar_date_time_adjust_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    cdta_in_if.sink    i_in,
    cdta_out_if.source o_out
);
    import cdta_pkg::*;

    logic       r_s1_valid;
    logic [2:0] r_s1_cmd;
    t_year      r_s1_year;
    t_month     r_s1_month;
    t_day       r_s1_day;
    t_hour      r_s1_hour;
    t_minute    r_s1_minute;
    t_amount    r_s1_amount;

    logic    r_out_valid;
    t_year   r_out_year;
    t_month  r_out_month;
    t_day    r_out_day;
    t_hour   r_out_hour;
    t_minute r_out_minute;

    logic s2_ready;
    logic s1_ready;

    assign s2_ready   = !r_out_valid || o_out.ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign i_in.ready = s1_ready;

    // saturated fields
    t_month  mo_s;
    t_day    dmax;
    t_day    d_s;
    t_hour   h_s;
    t_minute mi_s;
    t_amount amt_s;
    t_amount amd;

    // neighbor day results
    t_year   y_inc;
    t_year   y_dec;
    t_month  mo_prev;
    t_day    plen;
    t_year   nd_year;
    t_month  nd_month;
    t_day    nd_day;
    t_year   pd_year;
    t_month  pd_month;
    t_day    pd_day;
    logic [5:0] back_wrap;
    logic [6:0] min_sum;
    logic [6:0] min_borrow;

    t_year   n_year;
    t_month  n_month;
    t_day    n_day;
    t_hour   n_hour;
    t_minute n_minute;

    always_comb begin
        if (r_s1_month < MONTH_FIRST) begin
            mo_s = MONTH_FIRST;
        end else if (r_s1_month > MONTH_LAST) begin
            mo_s = MONTH_LAST;
        end else begin
            mo_s = r_s1_month;
        end
        dmax = month_len(r_s1_year, mo_s);
        if (r_s1_day < DAY_FIRST) begin
            d_s = DAY_FIRST;
        end else if (r_s1_day > dmax) begin
            d_s = dmax;
        end else begin
            d_s = r_s1_day;
        end
        h_s   = (r_s1_hour > HOUR_LAST) ? HOUR_LAST : r_s1_hour;
        mi_s  = (r_s1_minute > MINUTE_LAST) ? MINUTE_LAST : r_s1_minute;
        amt_s = (r_s1_amount > AMOUNT_LAST) ? AMOUNT_LAST : r_s1_amount;
        amd   = (amt_s > BACK_DAYS_MAX) ? BACK_DAYS_MAX : amt_s;

        y_inc   = r_s1_year + 16'd1;
        y_dec   = r_s1_year - 16'd1;
        mo_prev = (mo_s == MONTH_FIRST) ? MONTH_LAST : mo_s - 4'd1;
        // december is 31 days, so january borrows the same way
        plen    = month_len(r_s1_year, mo_prev);

        if (d_s == dmax) begin
            nd_day = DAY_FIRST;
            if (mo_s == MONTH_LAST) begin
                nd_month = MONTH_FIRST;
                nd_year  = y_inc;
            end else begin
                nd_month = mo_s + 4'd1;
                nd_year  = r_s1_year;
            end
        end else begin
            nd_day   = d_s + 5'd1;
            nd_month = mo_s;
            nd_year  = r_s1_year;
        end

        if (d_s == DAY_FIRST) begin
            pd_day   = plen;
            pd_month = mo_prev;
            pd_year  = (mo_s == MONTH_FIRST) ? y_dec : r_s1_year;
        end else begin
            pd_day   = d_s - 5'd1;
            pd_month = mo_s;
            pd_year  = r_s1_year;
        end

        back_wrap  = {1'b0, plen} - amd + {1'b0, d_s};
        min_sum    = {1'b0, mi_s} + {1'b0, amt_s};
        min_borrow = {1'b0, mi_s} + MIN_PER_HOUR - {1'b0, amt_s};

        n_year   = r_s1_year;
        n_month  = mo_s;
        n_day    = d_s;
        n_hour   = h_s;
        n_minute = mi_s;

        case (r_s1_cmd)
            CMD_NEXT_DAY: begin
                n_year  = nd_year;
                n_month = nd_month;
                n_day   = nd_day;
            end
            CMD_PREV_DAY: begin
                n_year  = pd_year;
                n_month = pd_month;
                n_day   = pd_day;
            end
            CMD_BACK_DAYS: begin
                if ({1'b0, d_s} <= amd) begin
                    n_year  = (mo_s == MONTH_FIRST) ? y_dec : r_s1_year;
                    n_month = mo_prev;
                    n_day   = back_wrap[4:0];
                end else begin
                    n_day = d_s - amd[4:0];
                end
            end
            CMD_ADD_MIN: begin
                if (min_sum >= MIN_PER_HOUR) begin
                    n_minute = 6'(min_sum - MIN_PER_HOUR);
                    if (h_s != HOUR_LAST) begin
                        n_hour = h_s + 5'd1;
                    end else begin
                        n_hour  = 5'd0;
                        n_year  = nd_year;
                        n_month = nd_month;
                        n_day   = nd_day;
                    end
                end else begin
                    n_minute = min_sum[5:0];
                end
            end
            CMD_SUB_MIN: begin
                if (mi_s >= amt_s) begin
                    n_minute = mi_s - amt_s;
                end else begin
                    n_minute = min_borrow[5:0];
                    if (h_s != 5'd0) begin
                        n_hour = h_s - 5'd1;
                    end else begin
                        n_hour  = HOUR_LAST;
                        n_year  = pd_year;
                        n_month = pd_month;
                        n_day   = pd_day;
                    end
                end
            end
            default: begin
                n_year = r_s1_year;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
        if (s1_ready && i_in.valid) begin
            r_s1_cmd    <= i_in.cmd;
            r_s1_year   <= i_in.year;
            r_s1_month  <= i_in.month;
            r_s1_day    <= i_in.day;
            r_s1_hour   <= i_in.hour;
            r_s1_minute <= i_in.minute;
            r_s1_amount <= i_in.amount;
        end
        if (s2_ready && r_s1_valid) begin
            r_out_year   <= n_year;
            r_out_month  <= n_month;
            r_out_day    <= n_day;
            r_out_hour   <= n_hour;
            r_out_minute <= n_minute;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_year   = r_out_year;
    assign o_out.out_month  = r_out_month;
    assign o_out.out_day    = r_out_day;
    assign o_out.out_hour   = r_out_hour;
    assign o_out.out_minute = r_out_minute;

endmodule

`default_nettype wire
